/* rtl/absb_pkg.sv */
// ----------------------------------------------------------------------------
// absb_pkg
// Shared constants, types and helper functions for the absolute-sum block.
// ----------------------------------------------------------------------------
package absb_pkg;

    localparam int MAX_MAGNITUDE = 2000;
    localparam int COUNT_BITS    = 20;

    localparam int NBINS  = 2 * MAX_MAGNITUDE + 1;
    localparam int BIN_AW = $clog2(NBINS);
    localparam int VAL_W  = 12;
    localparam int MAG_W  = $clog2(MAX_MAGNITUDE + 1);
    // Signed working width for bin indexes and element values.
    localparam int IW     = ((BIN_AW > VAL_W) ? BIN_AW : VAL_W) + 2;
    // Signed width of a prefix value sum.
    localparam int PSUM_W = COUNT_BITS + MAG_W + 1;
    localparam int PFX_W  = COUNT_BITS + PSUM_W;
    localparam int PW     = IW + COUNT_BITS + 1;
    localparam int OFS_W  = 32;
    localparam int OUT_W  = 52;
    localparam int DIFF_W = COUNT_BITS + 2;
    localparam int PROD_W = OFS_W + DIFF_W;
    localparam int BASE_W = PSUM_W + 2;
    localparam int TOT_W  = PROD_W + 2;
    localparam int EXT_W  = ((TOT_W > OUT_W) ? TOT_W : OUT_W) + 1;

    localparam logic signed [IW-1:0]    MAG_I = IW'(MAX_MAGNITUDE);
    localparam logic signed [OFS_W:0]   MAG_O = (OFS_W + 1)'(MAX_MAGNITUDE);
    localparam logic [BIN_AW-1:0]       LAST_BIN = BIN_AW'(NBINS - 1);
    localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W - 1){1'b1}}};
    localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W - 1){1'b0}}};
    localparam logic signed [EXT_W-1:0] SUM_MAX_X =
        {{(EXT_W - OUT_W){1'b0}}, {OUT_W{1'b1}}};

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WB,
        ST_BUILD,
        ST_Q_ADDR,
        ST_Q_MUL,
        ST_Q_SUM
    } t_state;

    typedef enum logic [1:0] {
        LK_LOW,
        LK_MID,
        LK_HIGH
    } t_lookup;

    typedef struct packed {
        logic              start;
        logic              issue;
        logic [BIN_AW-1:0] addr;
    } t_build_ctl;

    typedef struct packed {
        logic              vld;
        logic              done;
        logic [BIN_AW-1:0] addr;
        logic [PFX_W-1:0]  data;
    } t_pfx_wr;

    typedef struct packed {
        logic clr;
        logic step;
        logic lookup;
        logic mul;
    } t_q_ctl;

    // Bin index of an element, saturated to the ends of the histogram.
    function automatic logic [BIN_AW-1:0] bin_index(input logic signed [VAL_W-1:0] v);
        logic signed [IW-1:0] w;
        logic [BIN_AW-1:0]    idx;
        w = IW'(v);
        if (w > MAG_I) begin
            idx = LAST_BIN;
        end else if (w < -MAG_I) begin
            idx = '0;
        end else begin
            idx = BIN_AW'(w + MAG_I);
        end
        return idx;
    endfunction

    // Element value that a bin stands for.
    function automatic logic signed [IW-1:0] bin_value(input logic [BIN_AW-1:0] idx);
        return $signed({{(IW - BIN_AW){1'b0}}, idx}) - MAG_I;
    endfunction

endpackage

/* rtl/absb_ram.sv */
// ----------------------------------------------------------------------------
// absb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module absb_ram #(
    parameter int DEPTH = 4001,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/absb_prefix_build.sv */
// ----------------------------------------------------------------------------
// absb_prefix_build
// Prefix-table builder: turns the stream of bin counts into running count
// and running value-sum entries for the prefix RAM.
// ----------------------------------------------------------------------------
module absb_prefix_build (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  absb_pkg::t_build_ctl                i_ctl,
    input  logic [absb_pkg::COUNT_BITS-1:0]     i_bin_rd,
    output absb_pkg::t_pfx_wr                   o_wr
);

    logic                                  r_s1_vld;
    logic [absb_pkg::BIN_AW-1:0]           r_s1_addr;
    logic                                  r_s2_vld;
    logic [absb_pkg::BIN_AW-1:0]           r_s2_addr;
    logic [absb_pkg::COUNT_BITS-1:0]       r_s2_cnt;
    logic signed [absb_pkg::PSUM_W-1:0]    r_s2_prod;
    logic [absb_pkg::COUNT_BITS-1:0]       r_acc_cnt;
    logic signed [absb_pkg::PSUM_W-1:0]    r_acc_sum;

    logic signed [absb_pkg::IW-1:0]        s1_val;
    logic signed [absb_pkg::PW-1:0]        s1_prod;
    logic [absb_pkg::COUNT_BITS-1:0]       n_acc_cnt;
    logic signed [absb_pkg::PSUM_W-1:0]    n_acc_sum;

    always_comb begin
        s1_val    = absb_pkg::bin_value(r_s1_addr);
        s1_prod   = s1_val * $signed({1'b0, i_bin_rd});
        n_acc_cnt = r_acc_cnt + r_s2_cnt;
        n_acc_sum = r_acc_sum + r_s2_prod;
    end

    always_comb begin
        o_wr.vld  = r_s2_vld;
        o_wr.done = r_s2_vld && (r_s2_addr == absb_pkg::LAST_BIN);
        o_wr.addr = r_s2_addr;
        o_wr.data = {n_acc_cnt, n_acc_sum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_ctl.addr;
        r_s2_addr <= r_s1_addr;
        r_s2_cnt  <= i_bin_rd;
        r_s2_prod <= absb_pkg::PSUM_W'(s1_prod);
        if (i_ctl.start) begin
            r_acc_cnt <= '0;
            r_acc_sum <= '0;
        end else if (r_s2_vld) begin
            r_acc_cnt <= n_acc_cnt;
            r_acc_sum <= n_acc_sum;
        end
    end

endmodule

/* rtl/absb_query.sv */
// ----------------------------------------------------------------------------
// absb_query
// Running offset with saturation and the query datapath: prefix lookup
// address, one multiply, and the final saturated sum.
// ----------------------------------------------------------------------------
module absb_query (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  absb_pkg::t_q_ctl                     i_ctl,
    input  logic signed [absb_pkg::VAL_W-1:0]    i_query_offset,
    input  logic [absb_pkg::PFX_W-1:0]           i_pfx_rd,
    input  logic [absb_pkg::COUNT_BITS-1:0]      i_elem_total,
    input  logic signed [absb_pkg::PSUM_W-1:0]   i_value_total,
    output logic [absb_pkg::BIN_AW-1:0]          o_pfx_addr,
    output logic [absb_pkg::OUT_W-1:0]           o_sum,
    output logic                                 o_sat
);

    logic signed [absb_pkg::OFS_W-1:0]   r_offset;
    logic                                r_sat;
    absb_pkg::t_lookup                   r_mode;
    logic signed [absb_pkg::PROD_W-1:0]  r_prod;
    logic signed [absb_pkg::BASE_W-1:0]  r_base;

    logic signed [absb_pkg::OFS_W:0]     ofs_sum;
    logic signed [absb_pkg::OFS_W-1:0]   n_offset;
    logic signed [absb_pkg::OFS_W:0]     ofs_x;
    logic signed [absb_pkg::OFS_W:0]     addr_x;
    absb_pkg::t_lookup                   n_mode;
    logic [absb_pkg::COUNT_BITS-1:0]     cb;
    logic signed [absb_pkg::PSUM_W-1:0]  sb;
    logic signed [absb_pkg::DIFF_W-1:0]  diff;
    logic signed [absb_pkg::BASE_W-1:0]  s_x;
    logic signed [absb_pkg::BASE_W-1:0]  sb_x;
    logic signed [absb_pkg::BASE_W-1:0]  n_base;
    logic signed [absb_pkg::PROD_W-1:0]  n_prod;
    logic signed [absb_pkg::TOT_W-1:0]   total;

    // Saturating update of the running offset.
    always_comb begin
        ofs_sum = (absb_pkg::OFS_W + 1)'(r_offset) + (absb_pkg::OFS_W + 1)'(i_query_offset);
        if (ofs_sum[absb_pkg::OFS_W] != ofs_sum[absb_pkg::OFS_W-1]) begin
            n_offset = ofs_sum[absb_pkg::OFS_W] ? absb_pkg::OFS_MIN : absb_pkg::OFS_MAX;
        end else begin
            n_offset = ofs_sum[absb_pkg::OFS_W-1:0];
        end
    end

    // Bins below MAX_MAGNITUDE - offset hold the elements that stay negative.
    always_comb begin
        ofs_x  = (absb_pkg::OFS_W + 1)'(r_offset);
        addr_x = absb_pkg::MAG_O - ofs_x - (absb_pkg::OFS_W + 1)'(1);
        if (ofs_x >= absb_pkg::MAG_O) begin
            n_mode = absb_pkg::LK_LOW;
        end else if (ofs_x < -absb_pkg::MAG_O) begin
            n_mode = absb_pkg::LK_HIGH;
        end else begin
            n_mode = absb_pkg::LK_MID;
        end
        o_pfx_addr = addr_x[absb_pkg::BIN_AW-1:0];
    end

    // Sum = (S - 2*sb) + R * (N - 2*cb).
    always_comb begin
        case (r_mode)
            absb_pkg::LK_LOW: begin
                cb = '0;
                sb = '0;
            end
            absb_pkg::LK_HIGH: begin
                cb = i_elem_total;
                sb = i_value_total;
            end
            absb_pkg::LK_MID: begin
                cb = i_pfx_rd[absb_pkg::PFX_W-1:absb_pkg::PSUM_W];
                sb = $signed(i_pfx_rd[absb_pkg::PSUM_W-1:0]);
            end
            default: begin
                cb = '0;
                sb = '0;
            end
        endcase
        diff   = $signed({2'b00, i_elem_total}) - $signed({1'b0, cb, 1'b0});
        s_x    = absb_pkg::BASE_W'(i_value_total);
        sb_x   = absb_pkg::BASE_W'(sb);
        n_base = s_x - (sb_x <<< 1);
        n_prod = r_offset * diff;
    end

    always_comb begin
        total = absb_pkg::TOT_W'(r_prod) + absb_pkg::TOT_W'(r_base);
        if (total < 0) begin
            o_sum = '0;
        end else if (absb_pkg::EXT_W'(total) > absb_pkg::SUM_MAX_X) begin
            o_sum = '1;
        end else begin
            o_sum = absb_pkg::OUT_W'(total);
        end
        o_sat = r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_ctl.clr) begin
            r_offset <= '0;
        end else if (i_ctl.step) begin
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_sat <= (n_offset == absb_pkg::OFS_MAX) || (n_offset == absb_pkg::OFS_MIN);
        end
        if (i_ctl.lookup) begin
            r_mode <= n_mode;
        end
        if (i_ctl.mul) begin
            r_prod <= n_prod;
            r_base <= n_base;
        end
    end

endmodule

/* rtl/absolute_sum_after_offset.sv */
// ----------------------------------------------------------------------------
// absolute_sum_after_offset
// Histogram of small signed values with a saturating running offset; each
// query returns the sum of |value + offset| over all loaded elements.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake         Payload
//   input    in         i_valid/o_stall   i_opcode, i_element_value, i_query_offset
//   output   out        o_valid/i_stall   o_absolute_sum, o_offset_saturated
//
// A load is a read-modify-write of its bin in the bin RAM. A query with current
// prefix tables steps through offset update, prefix RAM read, multiply, and
// final add into the output register. The first query after a load or clear
// also walks all NBINS bins through the prefix builder, one bin per cycle as
// set by the single bin RAM read port. A clear item, and likewise reset,
// sweeps zeros through all NBINS (4001) bins of the bin RAM while o_stall stays
// high. Unused opcodes and loads into a full histogram are taken and dropped.
// The output register lets a finished result wait on i_stall while further
// items are taken; only the next result waits for it.
//
module absolute_sum_after_offset (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_opcode,
    input  logic signed [absb_pkg::VAL_W-1:0]   i_element_value,
    input  logic signed [absb_pkg::VAL_W-1:0]   i_query_offset,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [absb_pkg::OUT_W-1:0]          o_absolute_sum,
    output logic                                o_offset_saturated
);

    // Control state.
    absb_pkg::t_state                      r_state;
    absb_pkg::t_state                      n_state;
    logic [absb_pkg::BIN_AW-1:0]           r_walk;
    logic [absb_pkg::BIN_AW-1:0]           n_walk;
    logic                                  r_issue;
    logic                                  n_issue;
    logic [absb_pkg::COUNT_BITS-1:0]       r_elem_total;
    logic [absb_pkg::COUNT_BITS-1:0]       n_elem_total;
    logic signed [absb_pkg::PSUM_W-1:0]    r_value_total;
    logic signed [absb_pkg::PSUM_W-1:0]    n_value_total;
    logic                                  r_tables_valid;
    logic                                  n_tables_valid;
    logic [absb_pkg::BIN_AW-1:0]           r_ld_addr;
    logic [absb_pkg::BIN_AW-1:0]           n_ld_addr;

    // Output register.
    logic                                  r_out_vld;
    logic [absb_pkg::OUT_W-1:0]            r_out_sum;
    logic                                  r_out_sat;
    logic                                  load_out;

    // Datapath connections.
    logic                                  accept;
    absb_pkg::t_opcode                     op;
    logic [absb_pkg::BIN_AW-1:0]           ld_idx;
    logic signed [absb_pkg::IW-1:0]        ld_val;
    logic                                  full;
    logic                                  bin_we;
    logic [absb_pkg::BIN_AW-1:0]           bin_waddr;
    logic [absb_pkg::COUNT_BITS-1:0]       bin_wdata;
    logic [absb_pkg::BIN_AW-1:0]           bin_raddr;
    logic [absb_pkg::COUNT_BITS-1:0]       bin_rd;
    logic [absb_pkg::PFX_W-1:0]            pfx_rd;
    logic [absb_pkg::BIN_AW-1:0]           pfx_raddr;
    absb_pkg::t_build_ctl                  bctl;
    absb_pkg::t_pfx_wr                     pfx_wr;
    absb_pkg::t_q_ctl                      qctl;
    logic [absb_pkg::OUT_W-1:0]            q_sum;
    logic                                  q_sat;

    assign o_stall = (r_state != absb_pkg::ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign op      = absb_pkg::t_opcode'(i_opcode);
    assign ld_idx  = absb_pkg::bin_index(i_element_value);
    assign ld_val  = absb_pkg::bin_value(ld_idx);
    assign full    = (r_elem_total == '1);

    // The bin RAM is read at the load's bin on acceptance, or along the walk.
    assign bin_raddr = (r_state == absb_pkg::ST_BUILD) ? r_walk : ld_idx;

    absb_ram #(
        .DEPTH (absb_pkg::NBINS),
        .WIDTH (absb_pkg::COUNT_BITS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rd)
    );

    absb_ram #(
        .DEPTH (absb_pkg::NBINS),
        .WIDTH (absb_pkg::PFX_W)
    ) u_pfx_ram (
        .i_clk   (i_clk),
        .i_we    (pfx_wr.vld),
        .i_waddr (pfx_wr.addr),
        .i_wdata (pfx_wr.data),
        .i_raddr (pfx_raddr),
        .o_rdata (pfx_rd)
    );

    absb_prefix_build u_build (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (bctl),
        .i_bin_rd (bin_rd),
        .o_wr     (pfx_wr)
    );

    absb_query u_query (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (qctl),
        .i_query_offset (i_query_offset),
        .i_pfx_rd       (pfx_rd),
        .i_elem_total   (r_elem_total),
        .i_value_total  (r_value_total),
        .o_pfx_addr     (pfx_raddr),
        .o_sum          (q_sum),
        .o_sat          (q_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= absb_pkg::ST_CLEAR;
            r_walk         <= '0;
            r_issue        <= 1'b0;
            r_elem_total   <= '0;
            r_value_total  <= '0;
            r_tables_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_walk         <= n_walk;
            r_issue        <= n_issue;
            r_elem_total   <= n_elem_total;
            r_value_total  <= n_value_total;
            r_tables_valid <= n_tables_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_addr <= n_ld_addr;
    end

    always_comb begin
        n_state        = r_state;
        n_walk         = r_walk;
        n_issue        = r_issue;
        n_elem_total   = r_elem_total;
        n_value_total  = r_value_total;
        n_tables_valid = r_tables_valid;
        n_ld_addr      = r_ld_addr;
        bctl           = '0;
        qctl           = '0;
        bin_we         = 1'b0;
        bin_waddr      = r_walk;
        bin_wdata      = '0;
        load_out       = 1'b0;

        case (r_state)
            absb_pkg::ST_CLEAR: begin
                // Zero one bin per cycle.
                bin_we = 1'b1;
                n_walk = r_walk + 1'b1;
                if (r_walk == absb_pkg::LAST_BIN) begin
                    n_state = absb_pkg::ST_IDLE;
                end
            end
            absb_pkg::ST_IDLE: begin
                if (accept) begin
                    case (op)
                        absb_pkg::OP_LOAD: begin
                            if (!full) begin
                                n_ld_addr      = ld_idx;
                                n_elem_total   = r_elem_total + 1'b1;
                                n_value_total  = r_value_total + absb_pkg::PSUM_W'(ld_val);
                                n_tables_valid = 1'b0;
                                n_state        = absb_pkg::ST_LOAD_WB;
                            end
                        end
                        absb_pkg::OP_QUERY: begin
                            qctl.step = 1'b1;
                            if (r_tables_valid) begin
                                n_state = absb_pkg::ST_Q_ADDR;
                            end else begin
                                bctl.start = 1'b1;
                                n_walk     = '0;
                                n_issue    = 1'b1;
                                n_state    = absb_pkg::ST_BUILD;
                            end
                        end
                        absb_pkg::OP_CLEAR: begin
                            qctl.clr       = 1'b1;
                            n_walk         = '0;
                            n_elem_total   = '0;
                            n_value_total  = '0;
                            n_tables_valid = 1'b0;
                            n_state        = absb_pkg::ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            absb_pkg::ST_LOAD_WB: begin
                // The bin was read on acceptance; write back the count plus one.
                bin_we    = 1'b1;
                bin_waddr = r_ld_addr;
                bin_wdata = bin_rd + 1'b1;
                n_state   = absb_pkg::ST_IDLE;
            end
            absb_pkg::ST_BUILD: begin
                bctl.issue = r_issue;
                bctl.addr  = r_walk;
                if (r_issue) begin
                    n_walk = r_walk + 1'b1;
                    if (r_walk == absb_pkg::LAST_BIN) begin
                        n_issue = 1'b0;
                    end
                end
                if (pfx_wr.done) begin
                    n_tables_valid = 1'b1;
                    n_state        = absb_pkg::ST_Q_ADDR;
                end
            end
            absb_pkg::ST_Q_ADDR: begin
                qctl.lookup = 1'b1;
                n_state     = absb_pkg::ST_Q_MUL;
            end
            absb_pkg::ST_Q_MUL: begin
                qctl.mul = 1'b1;
                n_state  = absb_pkg::ST_Q_SUM;
            end
            absb_pkg::ST_Q_SUM: begin
                // Wait only if the previous result is still held.
                if (!r_out_vld || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = absb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = absb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_sum <= q_sum;
            r_out_sat <= q_sat;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_absolute_sum     = r_out_sum;
    assign o_offset_saturated = r_out_sat;

endmodule

/* rtl/absb_checker.sv */
// ----------------------------------------------------------------------------
// absb_checker
// Port-level checks for the absolute-sum block, bound to its top level.
// ----------------------------------------------------------------------------
module absb_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic [1:0]                          i_opcode,
    input logic signed [absb_pkg::VAL_W-1:0]   i_element_value,
    input logic signed [absb_pkg::VAL_W-1:0]   i_query_offset,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [absb_pkg::OUT_W-1:0]          o_absolute_sum,
    input logic                                o_offset_saturated
);

    // A result that is held back stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A result that is held back keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_absolute_sum) && $stable(o_offset_saturated))
        else $error("result payload changed while stalled");

    // Reset starts the clearing sweep and empties the output register.
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("reset did not start the clearing sweep");

    // A clear item starts the clearing sweep.
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_opcode == absb_pkg::OP_CLEAR) |=> o_stall)
        else $error("clear item did not start the sweep");

    // No result can appear in the cycle right after an item is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared too early");

endmodule

bind absolute_sum_after_offset absb_checker u_absb_checker (.*);
